/* hdl/sobel_edge_threshold_assert.svh */
// Assertion macros shared by the Sobel edge detector RTL.
`ifndef SOBEL_EDGE_THRESHOLD_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SOBET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SOBET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sobet_pkg.sv */
// Shared types, constants and register codes of the Sobel edge detector.
package sobet_pkg;

  localparam int MaxWidthDef = 1024;
  localparam int CfgW        = 11;
  localparam int PixW        = 8;
  localparam int SumW        = PixW + 2;
  localparam int GradW       = SumW + 1;
  localparam int SqW         = 20;
  localparam int MagW        = SqW + 1;
  localparam int ThSqW       = 2 * CfgW;
  localparam int QueueDepth  = 2;
  localparam int ApbAddrW    = 4;
  localparam int ApbDataW    = 32;

  localparam logic [CfgW-1:0]  RowSat       = 11'd2047;
  localparam logic [CfgW-1:0]  HeightLimit  = 11'd1024;
  localparam logic [CfgW-1:0]  DimMin       = 11'd3;
  localparam logic [CfgW-1:0]  ThresholdRst = 11'd120;
  localparam logic             InvertRst    = 1'b1;
  localparam logic [CfgW-1:0]  WidthRst     = 11'd256;
  localparam logic [CfgW-1:0]  HeightRst    = 11'd256;
  localparam logic [ThSqW-1:0] ThSqRst      = ThSqW'(120 * 120);
  localparam logic [PixW-1:0]  PixHigh      = 8'hFF;
  localparam logic [PixW-1:0]  PixLow       = 8'h00;
  localparam logic             KindPixel    = 1'b0;

  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegInvert    = 2'd1,
    RegWidth     = 2'd2,
    RegHeight    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic            kind;
    logic [PixW-1:0] pixel;
    logic            frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] out_value;
    logic            is_edge;
    logic            end_of_frame;
  } pix_out_t;

  // 3x3 neighborhood, [row][col], row 0 on top, col 0 on the left
  typedef logic [2:0][2:0][PixW-1:0] taps_t;

  typedef struct packed {
    taps_t taps;
    logic  eof;
  } win_item_t;

  typedef struct packed {
    logic [CfgW-1:0]  width;
    logic [CfgW-1:0]  height;
    logic [ThSqW-1:0] th_sq;
    logic             invert;
  } cfg_t;

endpackage

/* hdl/sobet_stream_if.sv */
// Valid/ready stream channel with a typed payload.
interface sobet_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/sobet_front.sv */
// Front end: raster counters, line store, window and masked neighborhood output.
`include "sobel_edge_threshold_assert.svh"

module sobet_front import sobet_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  sobet_stream_if.sink  in_i,
  sobet_stream_if.source win_o
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW = (CW + 1 > CfgW) ? CW + 1 : CfgW;
  localparam int LW = 2 * PixW;

  logic [CW-1:0]   col_q, col_d;
  logic [CfgW-1:0] row_q, row_d;
  logic            in_acc;
  logic            fs;
  logic [CW-1:0]   col_a;
  logic [CfgW-1:0] row_a;
  logic [PixW-1:0] pix_a;

  logic            s1_valid_q;
  logic [CW-1:0]   s1_col_q;
  logic [CfgW-1:0] s1_row_q;
  logic [PixW-1:0] s1_v_q;
  logic            s1_adv;

  logic [LW-1:0]   mem_q [MAX_WIDTH];
  logic [LW-1:0]   rd_q;
  logic            fwd_q;
  logic            zero_q;
  logic [LW-1:0]   fwd_data_q;
  logic [CW:0]     fill_q, fill_d;
  logic [LW-1:0]   rd_data;
  logic [LW-1:0]   wr_data;
  logic [PixW-1:0] up_px, mid_px;

  logic [2:0][PixW-1:0] win1_q, win2_q;
  logic [2:0][PixW-1:0] new_col;
  logic            col0;
  logic            emit;
  logic            mask_top;
  logic            mask_left;
  logic            eof;
  taps_t           taps;

  assign fs     = in_i.payload.frame_start;
  assign col_a  = fs ? '0 : col_q;
  assign row_a  = fs ? '0 : row_q;
  assign pix_a  = (in_i.payload.kind == KindPixel && row_a < cfg_i.height) ?
                  in_i.payload.pixel : '0;
  assign in_acc = in_i.valid && in_i.ready;

  assign s1_adv     = s1_valid_q && (!emit || win_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if ((XW'(col_a) + XW'(1)) >= XW'(cfg_i.width)) begin
        col_d = '0;
        row_d = (row_a < RowSat) ? row_a + 1'b1 : row_a;
      end else begin
        col_d = col_a + 1'b1;
        row_d = row_a;
      end
    end
  end

  // Line store entry holds {row two above, row above}
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_q[s1_col_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= mem_q[col_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q   <= col_a;
      s1_row_q   <= row_a;
      s1_v_q     <= pix_a;
      fwd_data_q <= wr_data;
    end
  end

  // Columns are written in ascending order from zero, so the written set is a prefix
  always_comb begin
    fill_d = fill_q;
    if (s1_adv && {1'b0, s1_col_q} >= fill_q) begin
      fill_d = {1'b0, s1_col_q} + 1'b1;
    end
  end

  assign rd_data = fwd_q ? fwd_data_q : (zero_q ? '0 : rd_q);
  assign up_px   = rd_data[LW-1:PixW];
  assign mid_px  = rd_data[PixW-1:0];
  assign wr_data = {mid_px, s1_v_q};
  assign new_col = {s1_v_q, mid_px, up_px};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fill_q     <= '0;
      fwd_q      <= 1'b0;
      zero_q     <= 1'b1;
      win1_q     <= '0;
      win2_q     <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      fill_q <= fill_d;
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (in_acc) begin
        // forward the entry written in this same edge
        fwd_q  <= s1_adv && (s1_col_q == col_a);
        zero_q <= ({1'b0, col_a} >= fill_q);
      end
      if (s1_adv) begin
        win1_q <= win2_q;
        win2_q <= new_col;
      end
    end
  end

  // At column zero the center is the last pixel of the row two above
  assign col0      = (s1_col_q == '0);
  assign emit      = col0 ?
                     (s1_row_q >= CfgW'(2) && s1_row_q < CfgW'(cfg_i.height + 2'd2)) :
                     (s1_row_q >= CfgW'(1) && s1_row_q < CfgW'(cfg_i.height + 1'b1));
  assign mask_top  = col0 ? (s1_row_q == CfgW'(2)) : (s1_row_q == CfgW'(1));
  assign mask_left = !col0 && (s1_col_q == CW'(1));
  assign eof       = col0 && (s1_row_q == CfgW'(cfg_i.height + 1'b1));

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      taps[r][0] = mask_left ? '0 : win1_q[r];
      taps[r][1] = win2_q[r];
      taps[r][2] = col0 ? '0 : new_col[r];
    end
    if (mask_top) begin
      taps[0] = '0;
    end
  end

  assign win_o.valid        = s1_valid_q && emit;
  assign win_o.payload.taps = taps;
  assign win_o.payload.eof  = eof;

  `SOBET_ASSERT_NEXT(a_frame_start_origin, in_acc && fs, s1_valid_q && s1_col_q == '0 && s1_row_q == '0, "frame start did not restart at origin")
  `SOBET_ASSERT_NEXT(a_fill_monotone, 1'b1, fill_q >= $past(fill_q), "line store fill count went down")
  `SOBET_ASSERT_NEXT(a_forward_same_col, in_acc && s1_adv && s1_col_q == col_a, fwd_q, "same-column line store write not forwarded")

endmodule

/* hdl/sobet_queue.sv */
// Two-entry queue between the front end and the gradient back end.
module sobet_queue import sobet_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  sobet_stream_if.sink   push_i,
  sobet_stream_if.source pop_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = PtrW + 1;

  win_item_t       slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_i.ready  = (cnt_q != CntW'(QueueDepth));
  assign pop_o.valid   = (cnt_q != '0);
  assign pop_o.payload = slot_q[rd_ptr_q];
  assign push          = push_i.valid && push_i.ready;
  assign pop           = pop_o.valid && pop_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/sobet_back.sv */
// Back end: gradients, squared magnitude, threshold compare and output register.
`include "sobel_edge_threshold_assert.svh"

module sobet_back import sobet_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_t           cfg_i,
  sobet_stream_if.sink   win_i,
  sobet_stream_if.source out_o
);

  logic                    adv;
  taps_t                   t;
  logic [SumW-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GradW-1:0] gx, gy;

  logic                    b1_valid_q;
  logic signed [GradW-1:0] b1_gx_q, b1_gy_q;
  logic                    b1_eof_q;
  logic signed [2*GradW-1:0] gx_sq, gy_sq;

  logic                    b2_valid_q;
  logic [SqW-1:0]          b2_gx2_q, b2_gy2_q;
  logic                    b2_eof_q;
  logic [MagW-1:0]         mag;
  logic                    is_edge;

  logic                    out_valid_q;
  pix_out_t                out_q;

  function automatic logic [SumW-1:0] wsum(logic [PixW-1:0] a, logic [PixW-1:0] b,
                                           logic [PixW-1:0] c);
    return SumW'(a) + SumW'({b, 1'b0}) + SumW'(c);
  endfunction

  assign adv         = !out_valid_q || out_o.ready;
  assign win_i.ready = adv;

  assign t      = win_i.payload.taps;
  assign gx_pos = wsum(t[0][2], t[1][2], t[2][2]);
  assign gx_neg = wsum(t[0][0], t[1][0], t[2][0]);
  assign gy_pos = wsum(t[0][0], t[0][1], t[0][2]);
  assign gy_neg = wsum(t[2][0], t[2][1], t[2][2]);
  assign gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
  assign gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

  assign gx_sq = b1_gx_q * b1_gx_q;
  assign gy_sq = b1_gy_q * b1_gy_q;

  assign mag     = MagW'(b2_gx2_q) + MagW'(b2_gy2_q);
  assign is_edge = (ThSqW'(mag) >= cfg_i.th_sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q  <= win_i.valid;
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_gx_q  <= gx;
      b1_gy_q  <= gy;
      b1_eof_q <= win_i.payload.eof;
      b2_gx2_q <= gx_sq[SqW-1:0];
      b2_gy2_q <= gy_sq[SqW-1:0];
      b2_eof_q <= b1_eof_q;
      out_q.out_value    <= (is_edge != cfg_i.invert) ? PixHigh : PixLow;
      out_q.is_edge      <= is_edge;
      out_q.end_of_frame <= b2_eof_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `SOBET_ASSERT_NOW(a_out_polarity, out_o.valid, out_o.payload.out_value == ((out_o.payload.is_edge != cfg_i.invert) ? PixHigh : PixLow), "output value disagrees with edge flag and polarity")
  `SOBET_ASSERT_NEXT(a_b1_to_b2, adv && b1_valid_q, b2_valid_q, "gradient stage lost a beat")
  `SOBET_ASSERT_NEXT(a_b2_hold, !adv && b2_valid_q, b2_valid_q && $stable(b2_gx2_q) && $stable(b2_gy2_q), "square stage changed while stalled")

endmodule

/* hdl/sobel_edge_threshold.sv */
// Sobel 3x3 edge detector with squared-magnitude threshold on a raster pixel stream.
// Throughput: one beat per cycle; a stalled output only backs up through a two-beat queue.
// Path: the beat that completes a window passes the front register, queue, gradient
// register, square register and output register before its result is valid.
// Reset: counters, window, queue and pipeline valids clear and registers take defaults;
// the line store is not swept, a fill count makes never-written columns read as zero.
module sobel_edge_threshold import sobet_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // pixel beats in, result beats out
  sobet_stream_if.sink        in_i,
  sobet_stream_if.source      out_o
);

  // Widths above 2047 cannot be programmed, so cap the clamp there
  localparam int              WCap = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
  localparam logic [CfgW-1:0] WMax = CfgW'(WCap);

  logic [CfgW-1:0]     threshold_q;
  logic                invert_q;
  logic [CfgW-1:0]     width_q;
  logic [CfgW-1:0]     height_q;
  logic [ThSqW-1:0]    th_sq_q;
  logic [ThSqW-1:0]    th_prod;
  logic                apb_wr;
  reg_idx_e            reg_idx;
  cfg_t                cfg;

  sobet_stream_if #(.payload_t(win_item_t)) win_push ();
  sobet_stream_if #(.payload_t(win_item_t)) win_pop ();

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; pready is tied
  // high so every transfer completes without wait states.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign apb_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);

  // Square the threshold once at write time so the datapath compares squares
  assign th_prod = pwdata[CfgW-1:0] * pwdata[CfgW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      th_sq_q     <= ThSqRst;
      invert_q    <= InvertRst;
      width_q     <= WidthRst;
      height_q    <= HeightRst;
    end else if (apb_wr) begin
      case (reg_idx)
        RegThreshold: begin
          threshold_q <= pwdata[CfgW-1:0];
          th_sq_q     <= th_prod;
        end
        RegInvert: begin
          invert_q <= pwdata[0];
        end
        RegWidth: begin
          width_q <= pwdata[CfgW-1:0];
        end
        RegHeight: begin
          height_q <= pwdata[CfgW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegThreshold: prdata = ApbDataW'(threshold_q);
      RegInvert:    prdata = ApbDataW'(invert_q);
      RegWidth:     prdata = ApbDataW'(width_q);
      RegHeight:    prdata = ApbDataW'(height_q);
      default:      prdata = '0;
    endcase
  end

  // Effective frame size: clamp out-of-range programming into the legal range
  always_comb begin
    cfg.width  = (width_q < DimMin) ? DimMin : ((width_q > WMax) ? WMax : width_q);
    cfg.height = (height_q < DimMin) ? DimMin :
                 ((height_q > HeightLimit) ? HeightLimit : height_q);
    cfg.th_sq  = th_sq_q;
    cfg.invert = invert_q;
  end

  // ---------------------------------------------------------------------------
  // Front end: tracks the raster position, reads and rewrites the line store
  // for the current column, shifts the window and pushes one masked 3x3
  // neighborhood per beat whose window is centered inside the frame.
  // ---------------------------------------------------------------------------
  sobet_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .win_o  (win_push)
  );

  // Decouple the window producer from the arithmetic so either side can stall
  sobet_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (win_push),
    .pop_o  (win_pop)
  );

  // ---------------------------------------------------------------------------
  // Back end: gradients, one squaring stage, then compare against the squared
  // threshold and map to the output polarity in the output register.
  // ---------------------------------------------------------------------------
  sobet_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .win_i  (win_pop),
    .out_o  (out_o)
  );

endmodule

/* test/sobel_edge_threshold_chk.sv */
// Scoreboard of the Sobel edge detector: follows the register writes, predicts and compares result beats.
module sobel_edge_threshold_chk import sobet_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  pix_in_t             in_beat_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  pix_out_t            out_beat_i,
  output int                  fails_o,
  output int                  pending_o
);

  logic [CfgW-1:0] thr_q, wid_q, hgt_q;
  logic            inv_q;

  logic [PixW-1:0] upper_ln  [MaxWidthDef];
  logic [PixW-1:0] middle_ln [MaxWidthDef];
  taps_t           win;
  int unsigned     col_cnt, row_cnt;

  pix_out_t        edge_px_q [$];
  int              fail_n;

  function automatic int unsigned clamp_dim(logic [CfgW-1:0] v, int unsigned hi);
    if (v < DimMin) return 32'(DimMin);
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic shift_window(logic [PixW-1:0] a, logic [PixW-1:0] b, logic [PixW-1:0] c);
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = a;
    win[1][2] = b;
    win[2][2] = c;
  endtask

  // One raster step: update line stores and window, queue the result it produces.
  task automatic advance_raster(pix_in_t b);
    int unsigned w, h, col, row, ctr_row, ctr_col, mag2, th2;
    int          gx, gy;
    logic [PixW-1:0] v, up, mid;
    taps_t       t;
    logic        hit, hit_edge;
    pix_out_t    res;
    if (b.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    w   = clamp_dim(wid_q, MaxWidthDef);
    h   = clamp_dim(hgt_q, 32'(HeightLimit));
    col = (col_cnt >= MaxWidthDef) ? MaxWidthDef - 1 : col_cnt;
    row = row_cnt;
    v   = (b.kind == KindPixel && row < h) ? b.pixel : PixLow;
    up  = upper_ln[col];
    mid = middle_ln[col];
    upper_ln[col]  = mid;
    middle_ln[col] = v;
    if (col == 0) begin
      // centre sits on the last column of the row two above
      for (int r = 0; r < 3; r++) begin
        t[r][0] = win[r][1];
        t[r][1] = win[r][2];
        t[r][2] = PixLow;
      end
      hit     = (row >= 2);
      ctr_row = hit ? row - 2 : 0;
      ctr_col = w - 1;
      shift_window(up, mid, v);
    end else begin
      shift_window(up, mid, v);
      t       = win;
      hit     = (row >= 1);
      ctr_row = hit ? row - 1 : 0;
      ctr_col = col - 1;
    end
    if (hit && ctr_row < h) begin
      if (ctr_row == 0) t[0] = '0;
      if (ctr_col == 0) for (int r = 0; r < 3; r++) t[r][0] = PixLow;
      gx = int'(t[0][2]) + 2 * int'(t[1][2]) + int'(t[2][2])
         - int'(t[0][0]) - 2 * int'(t[1][0]) - int'(t[2][0]);
      gy = int'(t[0][0]) + 2 * int'(t[0][1]) + int'(t[0][2])
         - int'(t[2][0]) - 2 * int'(t[2][1]) - int'(t[2][2]);
      mag2 = gx * gx + gy * gy;
      th2  = 32'(thr_q) * 32'(thr_q);
      hit_edge         = (mag2 >= th2);
      res.is_edge      = hit_edge;
      res.out_value    = (hit_edge ^ inv_q) ? PixHigh : PixLow;
      res.end_of_frame = (col == 0 && ctr_row == h - 1);
      edge_px_q.push_back(res);
    end
    if (col + 1 >= w) begin
      col_cnt = 0;
      if (row < RowSat) row_cnt = row + 1;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_out_t want;
    if (!rst_ni) begin
      thr_q     = ThresholdRst;
      inv_q     = InvertRst;
      wid_q     = WidthRst;
      hgt_q     = HeightRst;
      upper_ln  = '{default: '0};
      middle_ln = '{default: '0};
      win       = '0;
      col_cnt   = 0;
      row_cnt   = 0;
      fail_n    = 0;
      edge_px_q.delete();
      fails_o   <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (edge_px_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: out_value %0d is_edge %0b eof %0b",
                   $time, out_beat_i.out_value, out_beat_i.is_edge, out_beat_i.end_of_frame);
          fail_n++;
        end else begin
          want = edge_px_q.pop_front();
          if (out_beat_i.out_value !== want.out_value) begin
            $display("%0t: out_value expected %0d, actual %0d",
                     $time, want.out_value, out_beat_i.out_value);
            fail_n++;
          end
          if (out_beat_i.is_edge !== want.is_edge) begin
            $display("%0t: is_edge expected %0b, actual %0b",
                     $time, want.is_edge, out_beat_i.is_edge);
            fail_n++;
          end
          if (out_beat_i.end_of_frame !== want.end_of_frame) begin
            $display("%0t: end_of_frame expected %0b, actual %0b",
                     $time, want.end_of_frame, out_beat_i.end_of_frame);
            fail_n++;
          end
        end
      end
      if (in_valid_i && in_ready_i) advance_raster(in_beat_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[ApbAddrW-1:2]))
          RegThreshold: thr_q = pwdata_i[CfgW-1:0];
          RegInvert:    inv_q = pwdata_i[0];
          RegWidth:     wid_q = pwdata_i[CfgW-1:0];
          RegHeight:    hgt_q = pwdata_i[CfgW-1:0];
          default: ;
        endcase
      end
      fails_o   <= fail_n;
      pending_o <= edge_px_q.size();
    end
  end

endmodule

/* test/sobel_edge_threshold_tb.sv */
// Top of the Sobel edge detector testbench: clock, reset, pixel and register stimulus, verdict.
module sobel_edge_threshold_tb;
  import sobet_pkg::*;

  localparam logic KindFlush    = ~KindPixel;
  localparam int   StallMax     = 13;
  localparam int   QuietLimit   = 2000;  // cycles with no beat and no register access
  localparam int   SettleCycles = 30;    // at least the pipeline depth plus the longest output stall
  localparam int   RandomItems  = 1200;
  localparam int   NoLimit      = 1 << 24;

  // pixel content of a generated frame
  typedef enum int {PxNoise, PxBinary, PxRamp, PxFlat, PxChecker} px_style_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel, penable, pwrite, pready;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata, prdata;
  logic                idle_rx;     // receiver may stall in this phase
  bit                  idle_tx;     // sender may pause in this phase
  int                  fails, pending;
  int unsigned         beats_sent;
  int                  quiet_cycles = 0;

  sobet_stream_if #(.payload_t(pix_in_t))  pix_in_if ();
  sobet_stream_if #(.payload_t(pix_out_t)) pix_out_if ();

  sobel_edge_threshold u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (pix_in_if.sink),
    .out_o   (pix_out_if.source)
  );

  sobel_edge_threshold_chk u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .in_valid_i  (pix_in_if.valid),
    .in_ready_i  (pix_in_if.ready),
    .in_beat_i   (pix_in_if.payload),
    .out_valid_i (pix_out_if.valid),
    .out_ready_i (pix_out_if.ready),
    .out_beat_i  (pix_out_if.payload),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic pix_in_t mk_beat(logic kind, logic [PixW-1:0] px, logic fs);
    pix_in_t b;
    b.kind        = kind;
    b.pixel       = px;
    b.frame_start = fs;
    return b;
  endfunction

  // Offer one beat and hold it until the block takes it; pause first now and then while idle_tx is set.
  task automatic push_beat(pix_in_t b);
    if (idle_tx && $urandom_range(0, 7) == 0) begin
      pix_in_if.valid <= 1'b0;
      repeat ($urandom_range(1, StallMax)) @(posedge clk_i);
    end
    pix_in_if.valid   <= 1'b1;
    pix_in_if.payload <= b;
    do @(posedge clk_i); while (!pix_in_if.ready);
    beats_sent++;
  endtask

  // Flush beats carry random pixel bits; the block must ignore them.
  task automatic send_flush(int n);
    repeat (n) push_beat(mk_beat(KindFlush, 8'($urandom), 1'b0));
  endtask

  // Unstructured beats; a frame start shows up about once in fs_odds beats (never for 0).
  task automatic send_noise(int n, int fs_odds);
    repeat (n)
      push_beat(mk_beat(1'($urandom), 8'($urandom),
                        fs_odds != 0 && $urandom_range(1, fs_odds) == 1));
  endtask

  function automatic logic [PixW-1:0] pick_px(px_style_e s, int r, int c,
                                             logic [PixW-1:0] base);
    case (s)
      PxNoise:  return 8'($urandom);
      PxBinary: return $urandom_range(0, 1) ? PixHigh : PixLow;
      PxRamp:   return 8'(base + r * 9 + c * 5 + $urandom_range(0, 3));
      PxFlat:   return 8'(base + $urandom_range(0, 2));
      default:  return ((r + c) % 2 != 0) ? PixHigh : PixLow;
    endcase
  endfunction

  // Send a frame in raster order, frame start on the first pixel; stop after limit pixels.
  task automatic send_frame(int w, int h, px_style_e s, int limit);
    logic [PixW-1:0] base;
    int r, c, k;
    base = 8'($urandom);
    k    = 0;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        if (k < limit) begin
          push_beat(mk_beat(KindPixel, pick_px(s, r, c, base), r == 0 && c == 0));
          k++;
        end
      end
    end
  endtask

  // Setup cycle, then access cycle; the write lands at the edge where pready is seen.
  task automatic write_reg(reg_idx_e idx, logic [ApbDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and hold until every predicted beat is out and the pipeline is empty.
  task automatic settle();
    pix_in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned thr, int unsigned inv, int unsigned w, int unsigned h);
    settle();
    write_reg(RegThreshold, thr);
    write_reg(RegInvert, inv);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
  endtask

  // Output side: ready low in random bursts while idle_rx is set, high otherwise.
  initial begin
    pix_out_if.ready <= 1'b0;
    forever begin
      if (idle_rx && $urandom_range(0, 7) == 0) begin
        pix_out_if.ready <= 1'b0;
        repeat ($urandom_range(1, StallMax)) @(posedge clk_i);
      end else begin
        pix_out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((pix_in_if.valid && pix_in_if.ready) || (pix_out_if.valid && pix_out_if.ready) ||
        (psel && penable && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned start_cnt, done_cnt, thr, cur_w, cur_h, k;
    int          pick;
    bit          late;
    px_style_e   sty;

    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    pix_in_if.valid   <= 1'b0;
    pix_in_if.payload <= '0;
    idle_rx           <= 1'b0;
    idle_tx            = 1'b0;
    beats_sent         = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling. Keep the reset threshold and polarity; shrink to 3x3.
    write_reg(RegWidth, 3);
    write_reg(RegHeight, 3);
    send_frame(3, 3, PxChecker, 9);
    send_flush(4);

    // Below-range dimensions clamp to 3x3; threshold zero marks every pixel as an edge.
    set_config(0, 0, 2, 0);
    push_beat(mk_beat(KindFlush, PixHigh, 1'b1));  // flush opening a frame: zero at origin
    for (k = 1; k < 9; k++)
      push_beat(mk_beat(KindPixel, (k % 3 == 0) ? PixHigh : PixLow, 1'b0));
    // real pixels below the last row read as zero padding and drain the frame
    repeat (3) push_beat(mk_beat(KindPixel, PixHigh, 1'b0));
    send_flush(3);  // one finishes the drain, two run past the frame

    // Run past the frame with idling on both sides, then start a fresh frame.
    idle_tx  = 1'b1;
    idle_rx <= 1'b1;
    set_config(0, 1, 3, 3);
    send_frame(3, 3, PxNoise, 9);
    send_flush(4);
    send_noise(40, 0);
    send_frame(3, 3, PxRamp, 9);
    send_flush(4);

    // Random phases: mostly well-formed frames, some broken ones and noise.
    cur_w     = 3;
    cur_h     = 3;
    start_cnt = beats_sent;
    done_cnt  = 0;
    while (done_cnt < RandomItems) begin
      late = (done_cnt > RandomItems * 4 / 5);  // no idling in the closing stretch
      settle();
      idle_tx  = !late && $urandom_range(0, 3) != 0;
      idle_rx <= !late && $urandom_range(0, 3) != 0;

      cur_w = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 8);
      if ($urandom_range(0, 5) == 0) begin
        // change only the width, possibly in the middle of a frame
        write_reg(RegWidth, cur_w);
      end else begin
        cur_h = $urandom_range(3, 6);
        case ($urandom_range(0, 5))
          0:       thr = 0;
          1:       thr = 2047;
          2, 3:    thr = $urandom_range(0, 300);
          default: thr = $urandom_range(0, 1443);
        endcase
        write_reg(RegThreshold, thr);
        write_reg(RegInvert, $urandom_range(0, 1));
        write_reg(RegWidth, (cur_w == 3 && $urandom_range(0, 1)) ? $urandom_range(0, 2) : cur_w);
        write_reg(RegHeight, (cur_h == 3 && $urandom_range(0, 1)) ? $urandom_range(0, 2) : cur_h);
      end

      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 9);
        sty  = px_style_e'($urandom_range(0, 4));
        if (pick < 6) begin
          send_frame(cur_w, cur_h, sty, NoLimit);
          send_flush(cur_w + 1);
        end else if (pick == 6) begin
          // cut the frame short; the next frame start drops what is left
          send_frame(cur_w, cur_h, sty, $urandom_range(1, cur_w * cur_h - 1));
        end else if (pick == 7) begin
          // drain partly with real pixels below the frame
          send_frame(cur_w, cur_h, sty, NoLimit);
          k = $urandom_range(1, cur_w + 1);
          repeat (k) push_beat(mk_beat(KindPixel, 8'($urandom), 1'b0));
          send_flush(cur_w + 1 - k + $urandom_range(0, 3));
        end else if (pick == 8) begin
          // partial drain, then a new frame starts mid-drain
          send_frame(cur_w, cur_h, sty, NoLimit);
          send_flush($urandom_range(0, cur_w));
        end else begin
          send_noise($urandom_range(5, 30), 8);
        end
      end
      done_cnt = beats_sent - start_cnt;
    end

    settle();
    if (fails == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/sobet_pkg.sv
hdl/sobet_stream_if.sv
hdl/sobet_front.sv
hdl/sobet_queue.sv
hdl/sobet_back.sv
hdl/sobel_edge_threshold.sv
test/sobel_edge_threshold_chk.sv
test/sobel_edge_threshold_tb.sv
